/* hdl/mmtt_pkg.sv */
// ----------------------------------------------------------------------------
// mmtt_pkg: shared types and constants of the timer table
// Slot layout, request, mode and result codes, and table sizing.
// ----------------------------------------------------------------------------
package mmtt_pkg;

    localparam int SLOTS = 16;
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // slot index width
    localparam int CW    = $clog2(SLOTS + 1);                 // live count width

    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_STOP = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    localparam logic [2:0] MODE_ONCE     = 3'd0;
    localparam logic [2:0] MODE_INFINITE = 3'd1;
    localparam logic [2:0] MODE_EVERY    = 3'd2;
    localparam logic [2:0] MODE_AFTER    = 3'd3;
    localparam logic [2:0] MODE_UNTIL    = 3'd4;

    localparam logic [2:0] KIND_ADDED    = 3'd0;
    localparam logic [2:0] KIND_FULL     = 3'd1;
    localparam logic [2:0] KIND_STOPPED  = 3'd2;
    localparam logic [2:0] KIND_NOTFOUND = 3'd3;
    localparam logic [2:0] KIND_FIRED    = 3'd4;
    localparam logic [2:0] KIND_DONE     = 3'd5;

    typedef struct packed {
        logic [31:0] id;
        logic [2:0]  mode;
        logic [23:0] period;
        logic [31:0] elapsed;
    } t_slot;

    typedef struct packed {
        logic        fire;
        logic        drop;
        logic [31:0] elapsed;
    } t_verdict;

endpackage

/* hdl/multi_mode_timer_table.sv */
// ----------------------------------------------------------------------------
// multi_mode_timer_table: compact table of up to SLOTS software timers
// An add is taken while idle and its word appears on the next cycle; busy stays
// low. A stop or a tick walks the live slots through the slot memory, one
// slot per cycle, rewriting kept slots in place toward the front, with
// busy high until the walk through the single read port is done. Fired words
// come in table order, one per cycle at most, followed by the closing word
// with o_last set. Words are strobed by o_valid for one cycle and cannot be
// held off; no input is taken while busy.
// ----------------------------------------------------------------------------
module multi_mode_timer_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [2:0]  i_mode,
    input  logic [23:0] i_period,
    input  logic [31:0] i_timer_id,
    input  logic [15:0] i_delta,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [31:0] o_out_id,
    output logic        o_last
);
    import mmtt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state      r_state, n_state;
    logic [CW-1:0] r_live;
    logic [31:0]   r_next_id;
    logic [CW-1:0] r_rd;
    logic [CW-1:0] r_wr;
    logic          r_iss;
    logic          r_a_vld;
    t_slot         r_a_slot;
    logic          r_is_tick;
    logic [31:0]   r_tid;
    logic [15:0]   r_delta;
    logic          r_found;
    logic          r_o_vld;
    logic [2:0]    r_o_kind;
    logic [31:0]   r_o_id;
    logic          r_o_last;

    logic          accept;
    logic          iss;
    logic          fin;
    logic          add_ok;
    logic          we;
    logic [IW-1:0] waddr;
    t_slot         wdata;
    t_slot         rdata;
    t_slot         add_slot;
    t_slot         kept_slot;
    t_verdict      verdict;
    logic [32:0]   sum;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign add_ok = (r_live < CW'(SLOTS));
    assign iss    = (r_state == S_WALK) && (r_rd < r_live);
    assign fin    = (r_state == S_WALK) && (r_rd == r_live) && !r_iss && !r_a_vld;

    assign add_slot.id      = r_next_id;
    assign add_slot.mode    = i_mode;
    assign add_slot.period  = i_period;
    assign add_slot.elapsed = 32'd0;

    assign kept_slot.id      = r_a_slot.id;
    assign kept_slot.mode    = r_a_slot.mode;
    assign kept_slot.period  = r_a_slot.period;
    assign kept_slot.elapsed = verdict.elapsed;

    // write port: append on add, compacting write-back during a walk
    always_comb begin
        if (r_state == S_WALK) begin
            we    = r_a_vld && !verdict.drop;
            waddr = r_wr[IW-1:0];
            wdata = kept_slot;
        end else begin
            we    = accept && (i_req_type == REQ_ADD) && add_ok;
            waddr = r_live[IW-1:0];
            wdata = add_slot;
        end
    end

    mmtt_slot_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_rd[IW-1:0]),
        .o_rdata (rdata)
    );

    mmtt_rule u_rule (
        .i_slot    (r_a_slot),
        .i_is_tick (r_is_tick),
        .i_tid     (r_tid),
        .o_verdict (verdict)
    );

    // saturating advance of elapsed, registered ahead of the decision
    assign sum = {1'b0, rdata.elapsed} + {17'd0, r_delta};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_req_type == REQ_STOP || i_req_type == REQ_TICK)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= '0;
            r_next_id <= 32'd0;
            r_rd      <= '0;
            r_wr      <= '0;
            r_iss     <= 1'b0;
            r_a_vld   <= 1'b0;
            r_found   <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_o_vld <= 1'b0;
            if (r_state == S_IDLE) begin
                r_rd    <= '0;
                r_wr    <= '0;
                r_iss   <= 1'b0;
                r_a_vld <= 1'b0;
                r_found <= 1'b0;
                if (accept && i_req_type == REQ_ADD) begin
                    r_o_vld <= 1'b1;
                    if (add_ok) begin
                        r_live    <= r_live + 1'b1;
                        r_next_id <= r_next_id + 32'd1;
                    end
                end
            end else begin
                r_iss   <= iss;
                r_a_vld <= r_iss;
                if (iss) begin
                    r_rd <= r_rd + 1'b1;
                end
                if (r_a_vld) begin
                    if (!verdict.drop) begin
                        r_wr <= r_wr + 1'b1;
                    end else begin
                        r_found <= 1'b1;
                    end
                    if (verdict.fire) begin
                        r_o_vld <= 1'b1;
                    end
                end
                if (fin) begin
                    r_live  <= r_wr;
                    r_o_vld <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_tick <= (i_req_type == REQ_TICK);
            r_tid     <= i_timer_id;
            r_delta   <= (i_req_type == REQ_TICK) ? i_delta : 16'd0;
        end
        if (r_iss) begin
            r_a_slot.id      <= rdata.id;
            r_a_slot.mode    <= rdata.mode;
            r_a_slot.period  <= rdata.period;
            r_a_slot.elapsed <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        if (r_state == S_IDLE) begin
            r_o_last <= 1'b1;
            if (add_ok) begin
                r_o_kind <= KIND_ADDED;
                r_o_id   <= r_next_id;
            end else begin
                r_o_kind <= KIND_FULL;
                r_o_id   <= 32'd0;
            end
        end else if (fin) begin
            r_o_last <= 1'b1;
            if (r_is_tick) begin
                r_o_kind <= KIND_DONE;
                r_o_id   <= 32'd0;
            end else begin
                r_o_kind <= r_found ? KIND_STOPPED : KIND_NOTFOUND;
                r_o_id   <= r_tid;
            end
        end else begin
            r_o_last <= 1'b0;
            r_o_kind <= KIND_FIRED;
            r_o_id   <= r_a_slot.id;
        end
    end

    assign o_valid  = r_o_vld;
    assign o_kind   = r_o_kind;
    assign o_out_id = r_o_id;
    assign o_last   = r_o_last;

endmodule

/* hdl/mmtt_slot_ram.sv */
// ----------------------------------------------------------------------------
// mmtt_slot_ram: slot storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mmtt_slot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/mmtt_rule.sv */
// ----------------------------------------------------------------------------
// mmtt_rule: per-slot decision
// Decides fire / drop and the new elapsed count for one slot during a walk.
// ----------------------------------------------------------------------------
module mmtt_rule (
    input  mmtt_pkg::t_slot    i_slot,     // elapsed already advanced by delta
    input  logic               i_is_tick,
    input  logic [31:0]        i_tid,
    output mmtt_pkg::t_verdict o_verdict
);
    import mmtt_pkg::*;

    logic [32:0] diff;
    logic        gt;
    logic        ge;

    assign diff = {1'b0, i_slot.elapsed} - {9'b0, i_slot.period};
    assign ge   = !diff[32];
    assign gt   = !diff[32] && (diff[31:0] != 32'd0);

    always_comb begin
        o_verdict.fire    = 1'b0;
        o_verdict.drop    = 1'b0;
        o_verdict.elapsed = i_slot.elapsed;
        if (!i_is_tick) begin
            o_verdict.drop = (i_slot.id == i_tid);
        end else begin
            case (i_slot.mode)
                MODE_EVERY: begin
                    if (gt) begin
                        o_verdict.fire    = 1'b1;
                        o_verdict.elapsed = diff[31:0];
                    end
                end
                MODE_AFTER:    o_verdict.fire = ge;
                MODE_INFINITE: o_verdict.fire = 1'b1;
                MODE_ONCE: begin
                    o_verdict.fire = 1'b1;
                    o_verdict.drop = 1'b1;
                end
                MODE_UNTIL: begin
                    o_verdict.fire = !gt;
                    o_verdict.drop = gt;
                end
                default: ;  // unknown modes only count
            endcase
        end
    end

endmodule
